@@ design/dukpt_key_derivation_defines.svh @@
// Assertion macros for the key derivation engine
`ifndef DUKPT_KEY_DERIVATION_DEFINES_SVH
`define DUKPT_KEY_DERIVATION_DEFINES_SVH

// same-cycle implication
`define DKD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dkd assertion failed");

// next-cycle implication
`define DKD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dkd assertion failed");

`endif

@@ design/dkd_pkg.sv @@
package dkd_pkg;

  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_LEFT  = 1'b0,
    CFG_BASE_RIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_PIN  = 2'd1,
    ACT_DATA = 2'd2,
    ACT_NONE = 2'd3
  } act_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] serial_high;
    logic [63:0] serial_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] key_left;
    logic [63:0] key_right;
  } out_item_t;

  localparam int unsigned CTR_W = 21;
  localparam logic [63:0] KEY_VARIANT = 64'hC0C0_C0C0_0000_0000;
  localparam logic [63:0] PIN_VARIANT = 64'h0000_0000_0000_00FF;
  localparam logic [63:0] DATA_VARIANT = 64'h0000_0000_00FF_0000;
  // rounds whose key schedule shifts by two
  localparam logic [15:0] ROT_TWO = 16'h7EFC;

  localparam byte unsigned TAB_IP [64] = '{
    58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,
    64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam byte unsigned TAB_FP [64] = '{
    40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,
    37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam byte unsigned TAB_E [48] = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam byte unsigned TAB_P [32] = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  localparam byte unsigned TAB_PC1 [56] = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
    60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
    29,21,13,5,28,20,12,4};
  localparam byte unsigned TAB_PC2 [48] = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};

  localparam logic [3:0] SBOX [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}
  };

  function automatic logic [63:0] perm_ip(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) y[63-i] = x[64-TAB_IP[i]];
    return y;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] x);
    logic [63:0] y;
    for (int i = 0; i < 64; i++) y[63-i] = x[64-TAB_FP[i]];
    return y;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] x);
    logic [55:0] y;
    for (int i = 0; i < 56; i++) y[55-i] = x[64-TAB_PC1[i]];
    return y;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] x);
    logic [47:0] y;
    for (int i = 0; i < 48; i++) y[47-i] = x[56-TAB_PC2[i]];
    return y;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] sub);
    logic [47:0] e;
    logic [31:0] s;
    logic [31:0] p;
    logic [5:0]  six;
    for (int i = 0; i < 48; i++) e[47-i] = r[32-TAB_E[i]];
    e = e ^ sub;
    for (int j = 0; j < 8; j++) begin
      six = e[47-6*j -: 6];
      s[31-4*j -: 4] = SBOX[j][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = s[32-TAB_P[i]];
    return p;
  endfunction

endpackage

@@ design/dkd_des.sv @@
module dkd_des import dkd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        decrypt,
  input  logic [63:0] key,
  input  logic [63:0] din,
  output logic        done,
  output logic [63:0] dout
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        dec_r, dec_nxt;
  logic [3:0]  rnd_r, rnd_nxt;
  logic [27:0] c_r, c_nxt, d_r, d_nxt;
  logic [31:0] l_r, l_nxt, r_r, r_nxt;
  logic [27:0] c_cur, d_cur;
  logic        two;
  logic [3:0]  rnd_rev;

  assign rnd_rev = 4'd15 - rnd_r;
  assign two     = dec_r ? ROT_TWO[rnd_rev] : ROT_TWO[rnd_r];

  always_comb begin
    if (dec_r) begin
      c_cur = c_r;
      d_cur = d_r;
    end else if (two) begin
      c_cur = {c_r[25:0], c_r[27:26]};
      d_cur = {d_r[25:0], d_r[27:26]};
    end else begin
      c_cur = {c_r[26:0], c_r[27]};
      d_cur = {d_r[26:0], d_r[27]};
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dec_nxt  = dec_r;
    rnd_nxt  = rnd_r;
    c_nxt    = c_r;
    d_nxt    = d_r;
    l_nxt    = l_r;
    r_nxt    = r_r;
    if (busy_r) begin
      l_nxt   = r_r;
      r_nxt   = l_r ^ feistel(r_r, perm_pc2({c_cur, d_cur}));
      rnd_nxt = rnd_r + 4'd1;
      if (!dec_r) begin
        c_nxt = c_cur;
        d_nxt = d_cur;
      end else if (two) begin
        c_nxt = {c_r[1:0], c_r[27:2]};
        d_nxt = {d_r[1:0], d_r[27:2]};
      end else begin
        c_nxt = {c_r[0], c_r[27:1]};
        d_nxt = {d_r[0], d_r[27:1]};
      end
      if (rnd_r == 4'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt       = 1'b1;
      dec_nxt        = decrypt;
      rnd_nxt        = 4'd0;
      {c_nxt, d_nxt} = perm_pc1(key);
      {l_nxt, r_nxt} = perm_ip(din);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dec_r <= dec_nxt;
    rnd_r <= rnd_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    l_r   <= l_nxt;
    r_r   <= r_nxt;
  end

  assign done = done_r;
  assign dout = perm_fp({r_r, l_r});

endmodule

@@ design/dukpt_key_derivation.sv @@
// Channel  Ports                           Transfer when
// input    start, busy, in_item            start high, busy low
// result   out_valid, out_item             out_valid high, one cycle
// config   cfg_we, cfg_index, cfg_wdata    cfg_we high
//
// One DES round per cycle in a single shared round unit. Load: 6 DES
// operations. PIN key: two DES operations per set counter bit, none per
// clear bit. Data key adds 6 DES operations. Synchronous reset clears
// the initial key; results cannot be stalled.
module dukpt_key_derivation import dkd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_valid,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_wdata
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_STEPA  = 7'b0000100,
    ST_STEPB  = 7'b0001000,
    ST_WEND   = 7'b0010000,
    ST_LAUNCH = 7'b0100000,
    ST_WAIT   = 7'b1000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [63:0] bkl_r, bkr_r;
  logic [63:0] ikl_r, ikl_nxt, ikr_r, ikr_nxt;
  act_t        act_r, act_nxt;
  logic [CTR_W-1:0] ctr_r, ctr_nxt, acc_r, acc_nxt;
  logic [4:0]  bit_r, bit_nxt;
  logic [63:0] base_r, base_nxt;
  logic [63:0] kl_r, kl_nxt, kr_r, kr_nxt;
  logic [63:0] tmp_r, tmp_nxt;
  logic [63:0] d0_r, d0_nxt, d1_r, d1_nxt;
  logic [63:0] xm_r, xm_nxt;
  logic [63:0] resl_r, resl_nxt;
  logic        tsel_r, tsel_nxt;
  logic [1:0]  stg_r, stg_nxt;
  logic        ov_r, ov_nxt;
  out_item_t   oi_r, oi_nxt;

  logic        des_start, des_dec, des_done;
  logic [63:0] des_key, des_din, des_dout;
  logic [CTR_W-1:0] bitmask, acc_set;
  logic [63:0] k1, k2, regv, vmask;

  dkd_des u_des (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (des_start),
    .decrypt (des_dec),
    .key     (des_key),
    .din     (des_din),
    .done    (des_done),
    .dout    (des_dout)
  );

  assign bitmask = CTR_W'(1) << bit_r;
  assign acc_set = acc_r | bitmask;
  assign regv    = base_r | {{(64-CTR_W){1'b0}}, acc_r};
  assign vmask   = kr_r ^ KEY_VARIANT;
  assign k1      = tsel_r ? (kl_r ^ xm_r) : kl_r;
  assign k2      = tsel_r ? (kr_r ^ xm_r) : kr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bkl_r <= '0;
      bkr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_LEFT:  bkl_r <= cfg_wdata;
        CFG_BASE_RIGHT: bkr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    ikl_nxt   = ikl_r;
    ikr_nxt   = ikr_r;
    act_nxt   = act_r;
    ctr_nxt   = ctr_r;
    acc_nxt   = acc_r;
    bit_nxt   = bit_r;
    base_nxt  = base_r;
    kl_nxt    = kl_r;
    kr_nxt    = kr_r;
    tmp_nxt   = tmp_r;
    d0_nxt    = d0_r;
    d1_nxt    = d1_r;
    xm_nxt    = xm_r;
    resl_nxt  = resl_r;
    tsel_nxt  = tsel_r;
    stg_nxt   = stg_r;
    ov_nxt    = 1'b0;
    oi_nxt    = oi_r;
    des_start = 1'b0;
    des_dec   = 1'b0;
    des_key   = kl_r;
    des_din   = regv ^ kr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt = act_t'(in_item.action);
          unique case (act_t'(in_item.action))
            ACT_LOAD: begin
              kl_nxt    = bkl_r;
              kr_nxt    = bkr_r;
              xm_nxt    = KEY_VARIANT;
              d0_nxt    = {in_item.serial_high, in_item.serial_low[63:CTR_W], 5'd0};
              d1_nxt    = {in_item.serial_high, in_item.serial_low[63:CTR_W], 5'd0};
              tsel_nxt  = 1'b0;
              stg_nxt   = 2'd0;
              state_nxt = ST_LAUNCH;
            end
            ACT_PIN, ACT_DATA: begin
              kl_nxt    = ikl_r;
              kr_nxt    = ikr_r;
              ctr_nxt   = in_item.serial_low[CTR_W-1:0];
              base_nxt  = {in_item.serial_low[63:CTR_W], {CTR_W{1'b0}}};
              acc_nxt   = '0;
              bit_nxt   = 5'(CTR_W - 1);
              state_nxt = ST_SCAN;
            end
            ACT_NONE: begin
              ov_nxt = 1'b1;
              oi_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (ctr_r[bit_r]) begin
          acc_nxt   = acc_set;
          des_start = 1'b1;
          des_key   = kl_r;
          des_din   = (base_r | {{(64-CTR_W){1'b0}}, acc_set}) ^ kr_r;
          state_nxt = ST_STEPA;
        end else if (bit_r == 5'd0) begin
          state_nxt = ST_WEND;
        end else begin
          bit_nxt = bit_r - 5'd1;
        end
      end
      ST_STEPA: begin
        if (des_done) begin
          tmp_nxt   = des_dout ^ kr_r;
          des_start = 1'b1;
          des_key   = kl_r ^ KEY_VARIANT;
          des_din   = regv ^ vmask;
          state_nxt = ST_STEPB;
        end
      end
      ST_STEPB: begin
        if (des_done) begin
          kl_nxt = des_dout ^ vmask;
          kr_nxt = tmp_r;
          if (bit_r == 5'd0) begin
            state_nxt = ST_WEND;
          end else begin
            bit_nxt   = bit_r - 5'd1;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_WEND: begin
        if (act_r == ACT_PIN) begin
          ov_nxt    = 1'b1;
          oi_nxt    = '{key_left: kl_r ^ PIN_VARIANT, key_right: kr_r ^ PIN_VARIANT};
          state_nxt = ST_IDLE;
        end else begin
          kl_nxt    = kl_r ^ DATA_VARIANT;
          kr_nxt    = kr_r ^ DATA_VARIANT;
          d0_nxt    = kl_r ^ DATA_VARIANT;
          d1_nxt    = kr_r ^ DATA_VARIANT;
          xm_nxt    = '0;
          tsel_nxt  = 1'b0;
          stg_nxt   = 2'd0;
          state_nxt = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        des_start = 1'b1;
        unique case (stg_r)
          2'd0: begin
            des_key = k1;
            des_din = tsel_r ? d1_r : d0_r;
          end
          2'd1: begin
            des_key = k2;
            des_din = tmp_r;
            des_dec = 1'b1;
          end
          default: begin
            des_key = k1;
            des_din = tmp_r;
          end
        endcase
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (des_done) begin
          tmp_nxt   = des_dout;
          state_nxt = ST_LAUNCH;
          if (stg_r == 2'd2) begin
            stg_nxt = 2'd0;
            if (!tsel_r) begin
              resl_nxt = des_dout;
              tsel_nxt = 1'b1;
            end else begin
              ov_nxt    = 1'b1;
              oi_nxt    = '{key_left: resl_r, key_right: des_dout};
              state_nxt = ST_IDLE;
              if (act_r == ACT_LOAD) begin
                ikl_nxt = resl_r;
                ikr_nxt = des_dout;
              end
            end
          end else begin
            stg_nxt = stg_r + 2'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      ikl_r   <= '0;
      ikr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      ikl_r   <= ikl_nxt;
      ikr_r   <= ikr_nxt;
    end
    act_r  <= act_nxt;
    ctr_r  <= ctr_nxt;
    acc_r  <= acc_nxt;
    bit_r  <= bit_nxt;
    base_r <= base_nxt;
    kl_r   <= kl_nxt;
    kr_r   <= kr_nxt;
    tmp_r  <= tmp_nxt;
    d0_r   <= d0_nxt;
    d1_r   <= d1_nxt;
    xm_r   <= xm_nxt;
    resl_r <= resl_nxt;
    tsel_r <= tsel_nxt;
    stg_r  <= stg_nxt;
    oi_r   <= oi_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = ov_r;
  assign out_item  = oi_r;

endmodule

@@ design/dkd_checker.sv @@
`include "dukpt_key_derivation_defines.svh"

module dkd_checker import dkd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input in_item_t  in_item
);

  // a result without a new transfer is never followed by another
  `DKD_ASSERT_NEXT(a_single_strobe, out_valid && !(start && !busy), !out_valid)
  // the engine is free again once a result is shown
  `DKD_ASSERT_NOW(a_free_on_result, out_valid, !busy)
  // a keyed action keeps the engine occupied
  `DKD_ASSERT_NEXT(a_busy_after_key_start,
    start && !busy && in_item.action != ACT_NONE, busy && !out_valid)
  // an unused action answers in the next cycle
  `DKD_ASSERT_NEXT(a_none_answers, start && !busy && in_item.action == ACT_NONE, out_valid)

endmodule

bind dukpt_key_derivation dkd_checker u_dkd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .in_item   (in_item)
);

@@ tb/dukpt_key_derivation_tb.sv @@
`timescale 1ns / 100ps

module dukpt_key_derivation_tb;
  import dkd_pkg::*;

  localparam logic [63:0] CTR_MASK = 64'h1F_FFFF;
  localparam int unsigned IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  in_item_t pending_items[$];
  out_item_t expected_keys[$];
  logic [63:0] bdk_left = '0, bdk_right = '0;
  logic [63:0] ik_left = '0, ik_right = '0;
  int unsigned gap = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;
  bit no_gaps = 1'b0;

  dukpt_key_derivation DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] des_blk(logic [63:0] key, logic [63:0] data, bit dec);
    logic [55:0] cd;
    logic [27:0] c, d;
    logic [47:0] sk [16];
    logic [63:0] b, o, res;
    logic [31:0] l, r, t, s, p;
    logic [47:0] e;
    logic [5:0] six;
    for (int i = 0; i < 56; i++) cd[55-i] = key[64-TAB_PC1[i]];
    c = cd[55:28];
    d = cd[27:0];
    for (int i = 0; i < 16; i++) begin
      for (int k = 0; k < ((i == 0 || i == 1 || i == 8 || i == 15) ? 1 : 2); k++) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      cd = {c, d};
      for (int j = 0; j < 48; j++) sk[i][47-j] = cd[56-TAB_PC2[j]];
    end
    for (int i = 0; i < 64; i++) b[63-i] = data[64-TAB_IP[i]];
    l = b[63:32];
    r = b[31:0];
    for (int i = 0; i < 16; i++) begin
      for (int j = 0; j < 48; j++) e[47-j] = r[32-TAB_E[j]];
      e = e ^ sk[dec ? 15 - i : i];
      for (int j = 0; j < 8; j++) begin
        six = e[47-6*j -: 6];
        s[31-4*j -: 4] = SBOX[j][{six[5], six[0], six[4:1]}];
      end
      for (int j = 0; j < 32; j++) p[31-j] = s[32-TAB_P[j]];
      t = r;
      r = l ^ p;
      l = t;
    end
    o = {r, l};
    for (int i = 0; i < 64; i++) res[63-i] = o[64-TAB_FP[i]];
    return res;
  endfunction

  function automatic logic [63:0] tdes_enc(logic [63:0] k1, logic [63:0] k2, logic [63:0] x);
    return des_blk(k1, des_blk(k2, des_blk(k1, x, 1'b0), 1'b1), 1'b0);
  endfunction

  function automatic out_item_t derive_key(in_item_t it);
    out_item_t res;
    logic [63:0] l, r, nl, nr, vl, vr, acc, reg_v, data;
    res = '0;
    case (act_t'(it.action))
      ACT_LOAD: begin
        data = {it.serial_high, 48'(( it.serial_low & ~CTR_MASK) >> 16)};
        ik_left = tdes_enc(bdk_left, bdk_right, data);
        ik_right = tdes_enc(bdk_left ^ KEY_VARIANT, bdk_right ^ KEY_VARIANT, data);
        res = '{ik_left, ik_right};
      end
      ACT_PIN, ACT_DATA: begin
        l = ik_left;
        r = ik_right;
        acc = '0;
        for (int bitn = CTR_W - 1; bitn >= 0; bitn--) begin
          if (it.serial_low[bitn]) begin
            acc[bitn] = 1'b1;
            reg_v = (it.serial_low & ~CTR_MASK) | acc;
            nr = des_blk(l, reg_v ^ r, 1'b0) ^ r;
            vl = l ^ KEY_VARIANT;
            vr = r ^ KEY_VARIANT;
            nl = des_blk(vl, reg_v ^ vr, 1'b0) ^ vr;
            l = nl;
            r = nr;
          end
        end
        if (act_t'(it.action) == ACT_PIN) begin
          res = '{l ^ PIN_VARIANT, r ^ PIN_VARIANT};
        end else begin
          vl = l ^ DATA_VARIANT;
          vr = r ^ DATA_VARIANT;
          res = '{tdes_enc(vl, vr, vl), tdes_enc(vl, vr, vr)};
        end
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic logic [63:0] pick_counter();
    int unsigned sel;
    logic [63:0] ctr;
    sel = $urandom_range(0, 99);
    ctr = '0;
    if (sel < 70) begin
      for (int k = $urandom_range(1, 3); k > 0; k--) ctr[$urandom_range(0, CTR_W - 1)] = 1'b1;
    end else if (sel < 82) begin
      ctr = '0;
    end else if (sel < 95) begin
      ctr = 64'($urandom) & CTR_MASK;
    end else begin
      ctr = CTR_MASK;
    end
    return ctr;
  endfunction

  function automatic in_item_t make_item(act_t act, logic [15:0] sh, logic [63:0] sl);
    in_item_t it;
    it.action = act;
    it.serial_high = sh;
    it.serial_low = sl;
    return it;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_keys.push_back(derive_key(in_item));
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap == 0 && pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap > 0) begin
        gap--;
      end else if (pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
        start <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_keys.size() == 0) begin
        $error("unexpected result key_left %h key_right %h", out_item.key_left,
               out_item.key_right);
        mismatches++;
      end else begin
        if (out_item.key_left !== expected_keys[0].key_left) begin
          $error("key_left expected %h actual %h", expected_keys[0].key_left,
                 out_item.key_left);
          mismatches++;
        end
        if (out_item.key_right !== expected_keys[0].key_right) begin
          $error("key_right expected %h actual %h", expected_keys[0].key_right,
                 out_item.key_right);
          mismatches++;
        end
        void'(expected_keys.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_cfg(cfg_reg_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_BASE_LEFT) bdk_left = val;
    else bdk_right = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !start && expected_keys.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic add_random(int unsigned n);
    int unsigned sel;
    act_t act;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      act = sel < 15 ? ACT_LOAD : sel < 55 ? ACT_PIN : sel < 97 ? ACT_DATA : ACT_NONE;
      pending_items.push_back(make_item(act, 16'($urandom),
        ({$urandom, $urandom} & ~CTR_MASK) | pick_counter()));
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    pending_items.push_back(make_item(ACT_PIN, 16'h0000, 64'h0));
    pending_items.push_back(make_item(ACT_DATA, 16'hFFFF, 64'h0000_0000_0000_0005));
    pending_items.push_back(make_item(ACT_NONE, 16'hFFFF, '1));
    pending_items.push_back(make_item(ACT_LOAD, 16'h0000, 64'h0));
    pending_items.push_back(make_item(ACT_PIN, 16'h0000, 64'h0));
    drain();
    write_cfg(CFG_BASE_LEFT, '1);
    write_cfg(CFG_BASE_RIGHT, '1);
    pending_items.push_back(make_item(ACT_LOAD, 16'hFFFF, '1));
    pending_items.push_back(make_item(ACT_PIN, 16'hFFFF, '1));
    pending_items.push_back(make_item(ACT_DATA, 16'hFFFF, '1));
    pending_items.push_back(make_item(ACT_PIN, 16'hFFFF, ~CTR_MASK));
    pending_items.push_back(make_item(ACT_DATA, 16'hFFFF, ~CTR_MASK));
    pending_items.push_back(make_item(ACT_NONE, 16'h0000, 64'h0));
    drain();
    write_cfg(CFG_BASE_LEFT, 64'h0123_4567_89AB_CDEF);
    write_cfg(CFG_BASE_RIGHT, 64'hFEDC_BA98_7654_3210);
    pending_items.push_back(make_item(ACT_LOAD, 16'hFFFF, 64'hFFFF_FFFF_FFE0_0000));
    pending_items.push_back(make_item(ACT_PIN, 16'hFFFF, 64'hFFFF_FFFF_FFE0_0001));
    pending_items.push_back(make_item(ACT_DATA, 16'hFFFF, 64'hFFFF_FFFF_FFF0_0000));
    pending_items.push_back(make_item(ACT_PIN, 16'hFFFF, 64'hFFFF_FFFF_FFE0_0000));
    pending_items.push_back(make_item(ACT_DATA, 16'h8000, 64'h8000_0000_0000_0000));
    add_random(400);
    drain();
    for (int ph = 0; ph < 3; ph++) begin
      write_cfg(CFG_BASE_LEFT, {$urandom, $urandom});
      write_cfg(CFG_BASE_RIGHT, {$urandom, $urandom});
      add_random(370);
      drain();
    end
    write_cfg(CFG_BASE_LEFT, '0);
    write_cfg(CFG_BASE_RIGHT, '0);
    add_random(20);
    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
